// ----- sv/mm_pkg.sv -----
// Shared types, constants and codes of the matrix multiply block.
package mm_pkg;

    localparam int MAX_DIM_DEFAULT = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int DATA_W          = 32;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int FRAC_W          = 16;
    localparam int CFG_W           = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int POS_W           = 6;
    localparam int IDX_OUT_W       = 3;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_START  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_OF_A  = 2'd0,
        REG_INNER_SIZE = 2'd1,
        REG_COLS_OF_B  = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [1:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] element;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] product;
        logic [IDX_OUT_W-1:0]    out_row;
        logic [IDX_OUT_W-1:0]    out_col;
        logic                    last;
    } t_out_word;

    // One classified item waiting between the front and the back.
    typedef struct packed {
        t_cmd                    op;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] element;
    } t_job;

    // Bookkeeping that travels with each multiply-accumulate step.
    typedef struct packed {
        logic                 first;
        logic                 last_k;
        logic                 last;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
    } t_tag;

endpackage

// ----- sv/matrix_multiply.sv -----
// With the back end idle, a load word is written into the queue and then from its head into its store.
// A start issues rows*inner*cols multiply-accumulate steps, one per cycle; each step passes the
// store read, product and accumulate registers, and each finished sum is registered to the output.
// One load word is taken per cycle while the queue is not full; a start holds the back end while
// later words wait in the four-entry queue, and o_busy is high while it is full.
// Reset sets all dimensions to 8 and empties queue and pipeline, not the stores; no stalls out.
module matrix_multiply #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Command channel.
    input  logic                        i_start,
    output logic                        o_busy,
    input  mm_pkg::t_in_word            i_in,
    // Result channel.
    output logic                        o_valid,
    output mm_pkg::t_out_word           o_out,
    // Configuration write channel.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    // Dimension registers as software wrote them.
    logic [mm_pkg::CFG_W-1:0] r_rows_of_a;
    logic [mm_pkg::CFG_W-1:0] r_inner_size;
    logic [mm_pkg::CFG_W-1:0] r_cols_of_b;

    // Dimensions limited to the range 1 to MAX_DIM.
    logic [DIM_W-1:0] rows_dim;
    logic [DIM_W-1:0] inner_dim;
    logic [DIM_W-1:0] cols_dim;

    logic         push;
    logic         pop;
    logic         full;
    logic         empty;
    mm_pkg::t_job front_job;
    mm_pkg::t_job head_job;

    // Configuration is always ready; an index past the last register is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_of_a  <= mm_pkg::DIM_RESET;
            r_inner_size <= mm_pkg::DIM_RESET;
            r_cols_of_b  <= mm_pkg::DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (mm_pkg::t_cfg_reg'(i_cfg_index))
                mm_pkg::REG_ROWS_OF_A:  r_rows_of_a  <= i_cfg_data;
                mm_pkg::REG_INNER_SIZE: r_inner_size <= i_cfg_data;
                mm_pkg::REG_COLS_OF_B:  r_cols_of_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero dimension acts as one, and anything above MAX_DIM acts as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [mm_pkg::CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    assign rows_dim  = clamp_dim(r_rows_of_a);
    assign inner_dim = clamp_dim(r_inner_size);
    assign cols_dim  = clamp_dim(r_cols_of_b);

    // The front classifies each word; unused commands and loads beyond
    // the store are dropped here and never reach the queue.
    mm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_start (i_start),
        .i_word  (i_in),
        .i_full  (full),
        .o_busy  (o_busy),
        .o_push  (push),
        .o_job   (front_job)
    );

    // The queue keeps word order, so a load behind a start cannot disturb it.
    mm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // The back writes the stores and runs the product row by row.
    mm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rows  (rows_dim),
        .i_inner (inner_dim),
        .i_cols  (cols_dim),
        .i_job   (head_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_word  (o_out)
    );

endmodule

// ----- sv/mm_front.sv -----
// Front end: takes command words and classifies them into queue jobs.
module mm_front #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
    input  logic            i_start,
    input  mm_pkg::t_in_word i_word,
    input  logic            i_full,
    output logic            o_busy,
    output logic            o_push,
    output mm_pkg::t_job    o_job
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    mm_pkg::t_cmd cmd;
    logic         accept;
    logic         in_range;

    assign cmd      = mm_pkg::t_cmd'(i_word.command);
    assign accept   = i_start && !i_full;
    assign in_range = int'(i_word.position) < DEPTH;
    assign o_busy   = i_full;

    always_comb begin
        o_job.op       = cmd;
        o_job.position = i_word.position;
        o_job.element  = i_word.element;
        unique case (cmd)
            mm_pkg::CMD_LOAD_A,
            mm_pkg::CMD_LOAD_B: o_push = accept && in_range;
            mm_pkg::CMD_START:  o_push = accept;
            default:            o_push = 1'b0;
        endcase
    end

endmodule

// ----- sv/mm_queue.sv -----
// Short first-in first-out queue of jobs between the front and the back.
module mm_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  mm_pkg::t_job i_job,
    input  logic         i_pop,
    output mm_pkg::t_job o_job,
    output logic         o_full,
    output logic         o_empty
);

    localparam int PTR_W = $clog2(mm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mm_pkg::QUEUE_DEPTH + 1);

    mm_pkg::t_job     r_slot [mm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(mm_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == mm_pkg::QUEUE_DEPTH - 1) ? '0 :
                            r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == mm_pkg::QUEUE_DEPTH - 1) ? '0 :
                            r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/mm_back.sv -----
// Back end: element stores, loop sequencer and multiply-accumulate pipeline.
module mm_back #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT,
    localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DIM_W-1:0] i_rows,
    input  logic [DIM_W-1:0] i_inner,
    input  logic [DIM_W-1:0] i_cols,
    input  mm_pkg::t_job     i_job,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    output mm_pkg::t_out_word o_word
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ACC_W  = mm_pkg::PROD_W + $clog2(MAX_DIM) + 1;
    localparam int SAT_LO = mm_pkg::FRAC_W + mm_pkg::DATA_W - 1;

    logic signed [mm_pkg::DATA_W-1:0] left_mem  [DEPTH];
    logic signed [mm_pkg::DATA_W-1:0] right_mem [DEPTH];

    mm_pkg::t_state r_state;
    mm_pkg::t_state n_state;

    logic issue;
    logic take_start;
    logic we_left;
    logic we_right;

    // Sequencer.
    logic [DIM_W-1:0]  r_ra, r_ka, r_cb;
    logic [IDX_W-1:0]  r_row, r_col, r_k;
    logic [IDX_W-1:0]  n_row, n_col, n_k;
    logic [ADDR_W-1:0] r_a_addr, r_a_row, r_b_addr;
    logic [ADDR_W-1:0] n_a_addr, n_a_row, n_b_addr;
    logic              k_last, c_last, r_last;
    mm_pkg::t_tag      issue_tag;

    // Pipeline.
    logic                             r_s1_valid;
    mm_pkg::t_tag                     r_s1_tag;
    logic signed [mm_pkg::DATA_W-1:0] r_rd_a, r_rd_b;
    logic                             r_s2_valid;
    mm_pkg::t_tag                     r_s2_tag;
    logic signed [mm_pkg::PROD_W-1:0] r_prod;
    logic                             r_s3_done;
    mm_pkg::t_tag                     r_s3_tag;
    logic signed [ACC_W-1:0]          r_acc;
    logic signed [ACC_W-1:0]          sum;
    logic [ACC_W-1:SAT_LO]            acc_hi;
    logic                             fits;
    logic                             r_o_valid;
    mm_pkg::t_out_word                r_o_word;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mm_pkg::ST_IDLE: begin
                if (!i_empty && i_job.op == mm_pkg::CMD_START) begin
                    n_state = mm_pkg::ST_RUN;
                end
            end
            mm_pkg::ST_RUN: begin
                if (k_last && c_last && r_last) begin
                    n_state = mm_pkg::ST_IDLE;
                end
            end
            default: n_state = mm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        issue      = 1'b0;
        take_start = 1'b0;
        we_left    = 1'b0;
        we_right   = 1'b0;
        unique case (r_state)
            mm_pkg::ST_IDLE: begin
                o_pop      = !i_empty;
                take_start = !i_empty && i_job.op == mm_pkg::CMD_START;
                we_left    = !i_empty && i_job.op == mm_pkg::CMD_LOAD_A;
                we_right   = !i_empty && i_job.op == mm_pkg::CMD_LOAD_B;
            end
            mm_pkg::ST_RUN: issue = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Element stores: one write port for loads, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (we_left) begin
            left_mem[ADDR_W'(i_job.position)] <= i_job.element;
        end
        if (we_right) begin
            right_mem[ADDR_W'(i_job.position)] <= i_job.element;
        end
        r_rd_a <= left_mem[r_a_addr];
        r_rd_b <= right_mem[r_b_addr];
    end

    assign k_last = r_k == IDX_W'(r_ka - DIM_W'(1));
    assign c_last = r_col == IDX_W'(r_cb - DIM_W'(1));
    assign r_last = r_row == IDX_W'(r_ra - DIM_W'(1));

    always_comb begin
        issue_tag.first  = r_k == '0;
        issue_tag.last_k = k_last;
        issue_tag.last   = k_last && c_last && r_last;
        issue_tag.row    = mm_pkg::IDX_OUT_W'(r_row);
        issue_tag.col    = mm_pkg::IDX_OUT_W'(r_col);
    end

    // Step k fastest, then column, then row; addresses walk incrementally.
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_k      = r_k;
        n_a_addr = r_a_addr;
        n_a_row  = r_a_row;
        n_b_addr = r_b_addr;
        if (take_start) begin
            n_row    = '0;
            n_col    = '0;
            n_k      = '0;
            n_a_addr = '0;
            n_a_row  = '0;
            n_b_addr = '0;
        end else if (issue) begin
            if (!k_last) begin
                n_k      = r_k + IDX_W'(1);
                n_a_addr = r_a_addr + ADDR_W'(1);
                n_b_addr = r_b_addr + ADDR_W'(r_cb);
            end else if (!c_last) begin
                n_k      = '0;
                n_col    = r_col + IDX_W'(1);
                n_a_addr = r_a_row;
                n_b_addr = ADDR_W'(r_col) + ADDR_W'(1);
            end else begin
                n_k      = '0;
                n_col    = '0;
                n_row    = r_row + IDX_W'(1);
                n_a_row  = r_a_row + ADDR_W'(r_ka);
                n_a_addr = r_a_row + ADDR_W'(r_ka);
                n_b_addr = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_k      <= n_k;
        r_a_addr <= n_a_addr;
        r_a_row  <= n_a_row;
        r_b_addr <= n_b_addr;
        if (take_start) begin
            r_ra <= i_rows;
            r_ka <= i_inner;
            r_cb <= i_cols;
        end
    end

    assign sum    = (r_s2_tag.first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
    assign acc_hi = r_acc[ACC_W-1:SAT_LO];
    assign fits   = (&acc_hi) || !(|acc_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_done  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            r_s3_done  <= r_s2_valid && r_s2_tag.last_k;
            r_o_valid  <= r_s3_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tag <= issue_tag;
        r_s2_tag <= r_s1_tag;
        r_prod   <= r_rd_a * r_rd_b;
        r_s3_tag <= r_s2_tag;
        if (r_s2_valid) begin
            r_acc <= sum;
        end
        r_o_word.out_row <= r_s3_tag.row;
        r_o_word.out_col <= r_s3_tag.col;
        r_o_word.last    <= r_s3_tag.last;
        if (fits) begin
            r_o_word.product <= r_acc[SAT_LO:mm_pkg::FRAC_W];
        end else if (r_acc[ACC_W-1]) begin
            r_o_word.product <= {1'b1, {(mm_pkg::DATA_W-1){1'b0}}};
        end else begin
            r_o_word.product <= {1'b0, {(mm_pkg::DATA_W-1){1'b1}}};
        end
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;

endmodule
